// ===== hw/rtl/vab_pkg.sv =====
// Shared types and register codes for the volume bounding-box block.
// No dependencies.
package vab_pkg;

   localparam int SIZE_BITS   = 13;
   localparam int MARGIN_BITS = 12;
   localparam int OUT_BITS    = 12;
   localparam int NUM_AXES    = 3;

   typedef enum logic [1:0] {
      CSR_SIZE_X = 2'd0,
      CSR_SIZE_Y = 2'd1,
      CSR_SIZE_Z = 2'd2,
      CSR_MARGIN = 2'd3
   } csr_index_type;

   // size[0] is x, size[1] is y, size[2] is z
   typedef struct packed {
      logic [NUM_AXES-1:0][SIZE_BITS-1:0] size;
      logic [MARGIN_BITS-1:0]             margin;
   } cfg_type;

endpackage

// ===== hw/rtl/vab_csr.sv =====
// Configuration registers: volume sizes and crop margin.
// Depends on vab_pkg.
module vab_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [vab_pkg::SIZE_BITS-1:0]  csr_data,
   output vab_pkg::cfg_type               cfg
);

   vab_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (vab_pkg::csr_index_type'(csr_index))
            vab_pkg::CSR_SIZE_X: cfg_in.size[0] = csr_data;
            vab_pkg::CSR_SIZE_Y: cfg_in.size[1] = csr_data;
            vab_pkg::CSR_SIZE_Z: cfg_in.size[2] = csr_data;
            vab_pkg::CSR_MARGIN: cfg_in.margin  = csr_data[vab_pkg::MARGIN_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size[0] <= vab_pkg::SIZE_BITS'(1);
         cfg_ff.size[1] <= vab_pkg::SIZE_BITS'(1);
         cfg_ff.size[2] <= vab_pkg::SIZE_BITS'(1);
         cfg_ff.margin  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/vab_track.sv =====
// Raster position counters and per-axis min/max of object voxels.
// Depends on vab_pkg.
module vab_track #(
   parameter int COORD_BITS = 12
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  vab_pkg::cfg_type                               cfg,
   input  logic                                           step,
   input  logic                                           object,
   output logic                                           done,
   output logic [vab_pkg::NUM_AXES-1:0][COORD_BITS-1:0]   box_min,
   output logic [vab_pkg::NUM_AXES-1:0][COORD_BITS-1:0]   box_max,
   output logic [vab_pkg::NUM_AXES-1:0][COORD_BITS-1:0]   last_idx
);

   localparam int N  = vab_pkg::NUM_AXES;
   localparam int SW = (COORD_BITS + 1 > vab_pkg::SIZE_BITS) ?
                       COORD_BITS + 1 : vab_pkg::SIZE_BITS;
   localparam logic [SW-1:0] SIZE_CAP = SW'(1) << COORD_BITS;

   logic [N-1:0][COORD_BITS-1:0] pos_ff, pos_in;
   logic [N-1:0][COORD_BITS-1:0] min_ff, min_in;
   logic [N-1:0][COORD_BITS-1:0] max_ff, max_in;
   logic [N-1:0][SW-1:0]         size_eff;
   logic [N-1:0]                 at_end;
   logic                         start;

   // sizes of zero act as one, oversize is capped at the coordinate range
   always_comb begin
      for (int a = 0; a < N; a++) begin
         size_eff[a] = SW'(cfg.size[a]);
         if (size_eff[a] == '0)
            size_eff[a] = SW'(1);
         if (size_eff[a] > SIZE_CAP)
            size_eff[a] = SIZE_CAP;
         last_idx[a] = COORD_BITS'(size_eff[a] - SW'(1));
      end
   end

   // min/max restart from the current sizes at the first voxel of a volume
   assign start = (pos_ff == '0);

   always_comb begin
      for (int a = 0; a < N; a++) begin
         box_min[a] = start ? last_idx[a] : min_ff[a];
         box_max[a] = start ? '0 : max_ff[a];
         if (object) begin
            if (pos_ff[a] < box_min[a])
               box_min[a] = pos_ff[a];
            if (pos_ff[a] > box_max[a])
               box_max[a] = pos_ff[a];
         end
         at_end[a] = pos_ff[a] >= last_idx[a];
      end
   end

   assign done = &at_end;

   always_comb begin
      pos_in = pos_ff;
      min_in = min_ff;
      max_in = max_ff;
      if (step) begin
         if (done) begin
            pos_in = '0;
            min_in = last_idx;
            max_in = '0;
         end else begin
            min_in = box_min;
            max_in = box_max;
            if (!at_end[0]) begin
               pos_in[0] = pos_ff[0] + COORD_BITS'(1);
            end else begin
               pos_in[0] = '0;
               if (!at_end[1]) begin
                  pos_in[1] = pos_ff[1] + COORD_BITS'(1);
               end else begin
                  pos_in[1] = '0;
                  pos_in[2] = pos_ff[2] + COORD_BITS'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff <= min_in;
      max_ff <= max_in;
   end

endmodule

// ===== hw/rtl/vab_axis_fin.sv =====
// One axis of the final box: widen by margin, clamp to the volume,
// keep hi at or above lo. Depends on vab_pkg.
module vab_axis_fin #(
   parameter int COORD_BITS = 12
) (
   input  logic [COORD_BITS-1:0]               mn,
   input  logic [COORD_BITS-1:0]               mx,
   input  logic [COORD_BITS-1:0]               lim,
   input  logic [vab_pkg::MARGIN_BITS-1:0]     margin,
   output logic [vab_pkg::OUT_BITS-1:0]        lo,
   output logic [vab_pkg::OUT_BITS-1:0]        hi
);

   localparam int W = ((COORD_BITS > vab_pkg::MARGIN_BITS) ?
                       COORD_BITS : vab_pkg::MARGIN_BITS) + 1;

   logic [W-1:0] mn_w, mx_w, lim_w, m_w, a, b;

   always_comb begin
      mn_w  = W'(mn);
      mx_w  = W'(mx);
      lim_w = W'(lim);
      m_w   = W'(margin);
      a = (mn_w >= m_w) ? mn_w - m_w : '0;
      if (a > lim_w)
         a = lim_w;
      b = mx_w + m_w;
      if (b > lim_w)
         b = lim_w;
      if (b < a)
         b = a;
      lo = a[vab_pkg::OUT_BITS-1:0];
      hi = b[vab_pkg::OUT_BITS-1:0];
   end

endmodule

// ===== hw/rtl/volume_autocrop_bounding_box.sv =====
// Top level of the volume auto-crop bounding-box finder.
// Depends on vab_pkg, vab_csr, vab_track and vab_axis_fin.
//
// Voxels stream in raster order (x fastest, then y, then z), one item per
// clock cycle while no result is held by rsp_stall; a voxel greater than
// zero counts as object. Each item passes an input register and one pass of
// compare/select logic, and the last voxel of a volume loads one crop box
// into the result register. Other voxels yield no result.
// The only source of back-pressure is rsp_stall on a waiting result.
// Sizes and margin are to be written through the csr port between volumes;
// the block itself does not enforce this. A size of zero acts as one and
// sizes beyond the coordinate range are capped.
module volume_autocrop_bounding_box #(
   parameter int COORD_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [31:0]                    req_voxel_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [vab_pkg::OUT_BITS-1:0]          rsp_lo_x,
   output logic [vab_pkg::OUT_BITS-1:0]          rsp_lo_y,
   output logic [vab_pkg::OUT_BITS-1:0]          rsp_lo_z,
   output logic [vab_pkg::OUT_BITS-1:0]          rsp_hi_x,
   output logic [vab_pkg::OUT_BITS-1:0]          rsp_hi_y,
   output logic [vab_pkg::OUT_BITS-1:0]          rsp_hi_z,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [1:0]                            csr_index,
   input  logic [vab_pkg::SIZE_BITS-1:0]         csr_data
);

   localparam int N  = vab_pkg::NUM_AXES;
   localparam int OB = vab_pkg::OUT_BITS;

   vab_pkg::cfg_type cfg;

   logic               in_valid_ff, in_valid_in;
   logic signed [31:0] voxel_ff;
   logic               is_object;
   logic               out_free, step, done;

   logic [N-1:0][COORD_BITS-1:0] box_min, box_max, last_idx;
   logic [N-1:0][OB-1:0]         lo, hi;
   logic [N-1:0][OB-1:0]         lo_ff, hi_ff;
   logic                         rsp_valid_ff, rsp_valid_in;

   vab_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // the result register frees up when empty or when its item is taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign is_object   = (voxel_ff > 32'sd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall)
         voxel_ff <= req_voxel_value;
   end

   vab_track #(.COORD_BITS(COORD_BITS)) u_track (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .step     (step),
      .object   (is_object),
      .done     (done),
      .box_min  (box_min),
      .box_max  (box_max),
      .last_idx (last_idx)
   );

   for (genvar a = 0; a < N; a++) begin : g_axis
      vab_axis_fin #(.COORD_BITS(COORD_BITS)) u_fin (
         .mn     (box_min[a]),
         .mx     (box_max[a]),
         .lim    (last_idx[a]),
         .margin (cfg.margin),
         .lo     (lo[a]),
         .hi     (hi[a])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (step)
         rsp_valid_in = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && done) begin
         lo_ff <= lo;
         hi_ff <= hi;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_lo_x  = lo_ff[0];
   assign rsp_lo_y  = lo_ff[1];
   assign rsp_lo_z  = lo_ff[2];
   assign rsp_hi_x  = hi_ff[0];
   assign rsp_hi_y  = hi_ff[1];
   assign rsp_hi_z  = hi_ff[2];

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for volume_autocrop_bounding_box.
// Depends on vab_pkg and the block's RTL; a built-in predictor or a box typed into the
// directed plan checks every crop box while both channels idle and stall at random.
module testbench;

   typedef struct packed {
      logic [11:0] lo_x;
      logic [11:0] lo_y;
      logic [11:0] lo_z;
      logic [11:0] hi_x;
      logic [11:0] hi_y;
      logic [11:0] hi_z;
   } crop_box_type;

   typedef enum logic {ROW_VOXEL, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      vab_pkg::csr_index_type idx;
      logic [12:0]            data;
      logic signed [31:0]     voxel;
      logic                   typed;
      crop_box_type           box;
   } plan_row_type;

   localparam int PLAN_ROWS = 28;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic signed [31:0]     req_voxel_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [11:0]            rsp_lo_x, rsp_lo_y, rsp_lo_z, rsp_hi_x, rsp_hi_y, rsp_hi_z;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   vab_pkg::csr_index_type csr_index = vab_pkg::CSR_SIZE_X;
   logic [12:0]            csr_data = '0;

   // predictor state
   logic [12:0] size_reg [3];
   logic [11:0] margin_reg;
   logic [11:0] pos [3];
   logic [11:0] min_c [3];
   logic [11:0] max_c [3];

   crop_box_type pending_boxes [$];
   int           mismatches = 0;
   logic         quiet_phase = 1'b0;
   int           rsp_hold = 0;
   int           stall_pick;
   plan_row_type directed_plan [PLAN_ROWS];

   volume_autocrop_bounding_box dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_voxel_value (req_voxel_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lo_x        (rsp_lo_x),
      .rsp_lo_y        (rsp_lo_y),
      .rsp_lo_z        (rsp_lo_z),
      .rsp_hi_x        (rsp_hi_x),
      .rsp_hi_y        (rsp_hi_y),
      .rsp_hi_z        (rsp_hi_z),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #50_000_000;
      $display("FAILURE");
      $finish;
   end

   // zero acts as one, anything past 4096 is capped
   function automatic logic [11:0] last_coord(input logic [12:0] sz);
      if (sz == 13'd0)
         return 12'd0;
      if (sz > 13'd4096)
         return 12'd4095;
      return 12'(sz - 13'd1);
   endfunction

   function automatic void restart_volume();
      for (int a = 0; a < 3; a++) begin
         pos[a]   = '0;
         min_c[a] = last_coord(size_reg[a]);
         max_c[a] = '0;
      end
   endfunction

   function automatic bit take_voxel(input logic signed [31:0] v, output crop_box_type box);
      logic [11:0] lim [3];
      logic [11:0] lo_c [3];
      logic [11:0] hi_c [3];
      bit          at_end [3];
      int          lo_v, hi_v;
      for (int a = 0; a < 3; a++)
         lim[a] = last_coord(size_reg[a]);
      if (pos[0] == 0 && pos[1] == 0 && pos[2] == 0)
         restart_volume();
      for (int a = 0; a < 3; a++) begin
         if (v > 0) begin
            if (pos[a] < min_c[a]) min_c[a] = pos[a];
            if (pos[a] > max_c[a]) max_c[a] = pos[a];
         end
         at_end[a] = pos[a] >= lim[a];
      end
      box = '0;
      if (at_end[0] && at_end[1] && at_end[2]) begin
         for (int a = 0; a < 3; a++) begin
            lo_v = int'(min_c[a]) - int'(margin_reg);
            hi_v = int'(max_c[a]) + int'(margin_reg);
            if (lo_v < 0) lo_v = 0;
            if (lo_v > int'(lim[a])) lo_v = int'(lim[a]);
            if (hi_v > int'(lim[a])) hi_v = int'(lim[a]);
            if (hi_v < lo_v) hi_v = lo_v;
            lo_c[a] = 12'(lo_v);
            hi_c[a] = 12'(hi_v);
         end
         box.lo_x = lo_c[0];
         box.lo_y = lo_c[1];
         box.lo_z = lo_c[2];
         box.hi_x = hi_c[0];
         box.hi_y = hi_c[1];
         box.hi_z = hi_c[2];
         restart_volume();
         return 1'b1;
      end
      if (!at_end[0]) begin
         pos[0] = pos[0] + 12'd1;
      end else begin
         pos[0] = '0;
         if (!at_end[1]) begin
            pos[1] = pos[1] + 12'd1;
         end else begin
            pos[1] = '0;
            pos[2] = pos[2] + 12'd1;
         end
      end
      return 1'b0;
   endfunction

   function automatic int pick_gap();
      int pick;
      if (quiet_phase)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 65)
         return 0;
      if (pick < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [31:0] make_voxel(input int per_mille);
      logic [31:0] raw;
      int          pick;
      raw  = $urandom();
      pick = $urandom_range(0, 9);
      if (int'($urandom_range(0, 999)) < per_mille) begin
         if (pick == 0) return 32'h7FFF_FFFF;
         if (pick == 1) return 32'sd1;
         if (raw[30:0] == '0) return 32'sd1;
         return {1'b0, raw[30:0]};
      end
      if (pick < 4) return 32'sd0;
      if (pick == 4) return 32'h8000_0000;
      if (pick == 5) return -32'sd1;
      return {1'b1, raw[30:0]};
   endfunction

   // leaves req_valid high so back-to-back items need no extra edge
   task automatic send_voxel(input logic signed [31:0] v, input logic typed,
                             input crop_box_type typed_box);
      int           gap;
      bit           got;
      crop_box_type box;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_voxel_value <= v;
      do @(posedge clock); while (req_stall);
      got = take_voxel(v, box);
      if (typed)
         pending_boxes.push_back(typed_box);
      else if (got)
         pending_boxes.push_back(box);
   endtask

   // caller lowers csr_valid after the last write of a batch
   task automatic write_reg(input vab_pkg::csr_index_type idx, input logic [12:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         vab_pkg::CSR_MARGIN: margin_reg = data[11:0];
         default:             size_reg[idx] = data;
      endcase
   endtask

   // wait out every expected box plus the pipeline depth
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_boxes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset || quiet_phase) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 55) begin
            rsp_stall <= 1'b0;
            rsp_hold  <= $urandom_range(0, 6);
         end else if (stall_pick < 94) begin
            rsp_stall <= 1'b1;
            rsp_hold  <= $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            rsp_hold  <= $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      crop_box_type want, seen;
      logic [71:0]  want_bits, seen_bits;
      string        field_names [6];
      field_names = '{"hi_z", "hi_y", "hi_x", "lo_z", "lo_y", "lo_x"};
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_lo_x, rsp_lo_y, rsp_lo_z, rsp_hi_x, rsp_hi_y, rsp_hi_z};
         if (pending_boxes.size() == 0) begin
            mismatches++;
            $display("%0t: box with nothing expected, lo=(%0d,%0d,%0d) hi=(%0d,%0d,%0d)",
                     $time, rsp_lo_x, rsp_lo_y, rsp_lo_z, rsp_hi_x, rsp_hi_y, rsp_hi_z);
         end else begin
            want      = pending_boxes.pop_front();
            want_bits = want;
            seen_bits = seen;
            for (int k = 0; k < 6; k++) begin
               if (want_bits[k*12 +: 12] !== seen_bits[k*12 +: 12]) begin
                  mismatches++;
                  $display("%0t: %s expected %0d, got %0d", $time, field_names[k],
                           want_bits[k*12 +: 12], seen_bits[k*12 +: 12]);
               end
            end
         end
      end
   end

   initial begin
      int          phase, big_done, sent, count, vol, per_mille, pick;
      bit          big, wrote;
      logic [12:0] sz;

      for (int a = 0; a < 3; a++)
         size_reg[a] = 13'd1;
      margin_reg = '0;
      restart_volume();

      // 1x1x1 volumes first, then empty volume, margin saturation, mid-volume resize
      directed_plan = '{
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd0,        1'b1, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'h7FFF_FFFF, 1'b1, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'h8000_0000, 1'b1, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd1,        1'b1, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    -32'sd1,       1'b1, '0},
         '{ROW_WRITE, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd0,        1'b0, '0},
         '{ROW_WRITE, vab_pkg::CSR_SIZE_Y, 13'd2,    32'sd0,        1'b0, '0},
         '{ROW_WRITE, vab_pkg::CSR_SIZE_Z, 13'd2,    32'sd0,        1'b0, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd0,        1'b0, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd0,        1'b0, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd0,        1'b0, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd0,        1'b1,
           '{12'd0, 12'd1, 12'd1, 12'd0, 12'd1, 12'd1}},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd0,        1'b0, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd5,        1'b0, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd0,        1'b0, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd0,        1'b0, '0},
         '{ROW_WRITE, vab_pkg::CSR_MARGIN, 13'h1FFF, 32'sd0,        1'b0, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd0,        1'b0, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd0,        1'b0, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd7,        1'b0, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd0,        1'b0, '0},
         '{ROW_WRITE, vab_pkg::CSR_SIZE_X, 13'd3,    32'sd0,        1'b0, '0},
         '{ROW_WRITE, vab_pkg::CSR_SIZE_Y, 13'd1,    32'sd0,        1'b0, '0},
         '{ROW_WRITE, vab_pkg::CSR_SIZE_Z, 13'd1,    32'sd0,        1'b0, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd9,        1'b0, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd0,        1'b0, '0},
         '{ROW_WRITE, vab_pkg::CSR_SIZE_X, 13'd2,    32'sd0,        1'b0, '0},
         '{ROW_VOXEL, vab_pkg::CSR_SIZE_X, 13'd0,    32'sd0,        1'b0, '0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (directed_plan[i].kind == ROW_WRITE) begin
            if (i == 0 || directed_plan[i-1].kind != ROW_WRITE)
               settle();
            write_reg(directed_plan[i].idx, directed_plan[i].data);
            if (i + 1 == PLAN_ROWS || directed_plan[i+1].kind != ROW_WRITE)
               csr_valid <= 1'b0;
         end else begin
            send_voxel(directed_plan[i].voxel, directed_plan[i].typed, directed_plan[i].box);
         end
      end

      // small random volumes; in every fourth phase, up to three times, one axis goes
      // to a size above 2048 (often full size or beyond) and only the start of that volume
      // is sent. A phase may stop mid-volume, so the next size write lands mid-volume.
      phase    = 0;
      big_done = 0;
      sent     = 0;
      while (sent < 400 || big_done < 3) begin
         settle();
         phase++;
         big = (phase % 4 == 2) && (big_done < 3);
         quiet_phase <= big || ($urandom_range(0, 4) == 0);
         wrote = 1'b0;
         for (int a = 0; a < 3; a++) begin
            if (big) begin
               if (a == big_done) begin
                  case ($urandom_range(0, 3))
                     0:       sz = 13'd4096;
                     1:       sz = 13'h1FFF;
                     2:       sz = 13'($urandom_range(4097, 8190));
                     default: sz = 13'($urandom_range(2049, 4095));
                  endcase
               end else begin
                  sz = 13'($urandom_range(0, 1));
               end
            end else begin
               pick = $urandom_range(0, 9);
               if (pick == 0)
                  sz = 13'd0;
               else if (pick == 9)
                  sz = 13'($urandom_range(5, 8));
               else
                  sz = 13'($urandom_range(1, 4));
            end
            if (big || $urandom_range(0, 4) != 0) begin
               write_reg(vab_pkg::csr_index_type'(a), sz);
               wrote = 1'b1;
            end
         end
         if (big || $urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
               sz = 13'd0;
            else if (pick < 7)
               sz = 13'($urandom_range(1, 3));
            else if (pick < 9)
               sz = 13'($urandom_range(4, 12));
            else
               sz = 13'($urandom());
            write_reg(vab_pkg::CSR_MARGIN, sz);
            wrote = 1'b1;
         end
         if (wrote)
            csr_valid <= 1'b0;

         vol = 1;
         for (int a = 0; a < 3; a++)
            vol = vol * (int'(last_coord(size_reg[a])) + 1);
         if (big) begin
            count = $urandom_range(20, 40);
            case ($urandom_range(0, 2))
               0:       per_mille = 0;
               1:       per_mille = 1;
               default: per_mille = 5;
            endcase
         end else begin
            count = vol * $urandom_range(1, 3);
            if ($urandom_range(0, 4) == 0)
               count = count + $urandom_range(0, vol - 1);
            if (count > 400 - sent)
               count = (sent < 400) ? 400 - sent : 0;
            case ($urandom_range(0, 4))
               0:       per_mille = 0;
               1:       per_mille = 50;
               2:       per_mille = 200;
               3:       per_mille = 500;
               default: per_mille = 1000;
            endcase
         end
         for (int n = 0; n < count; n++)
            send_voxel(make_voxel(per_mille), 1'b0, '0);
         if (big)
            big_done++;
         sent = sent + count;
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_boxes.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
